### sv/wis_pkg.sv
package wis_pkg;

   localparam int NUM_WARPS  = 8;
   localparam int PROG_DEPTH = 64;
   localparam int NUM_REGS   = 64;
   localparam int MAX_SRCS   = 3;

   localparam int WARP_W  = 3;
   localparam int PC_W    = $clog2(PROG_DEPTH + 1);
   localparam int PADDR_W = $clog2(PROG_DEPTH);
   localparam int REG_W   = $clog2(NUM_REGS);
   localparam int IADDR_W = WARP_W + PADDR_W;
   localparam int SADDR_W = WARP_W + REG_W;
   localparam int INST_W  = 42;
   localparam int NSRC    = (MAX_SRCS < 3) ? MAX_SRCS : 3;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_TICK    = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OC_ISSUED  = 3'd0,
      OC_BARRIER = 3'd1,
      OC_MEMORY  = 3'd2,
      OC_RAW     = 3'd3,
      OC_STRUCT  = 3'd4,
      OC_IDLE    = 3'd5,
      OC_LOADED  = 3'd6,
      OC_FULL    = 3'd7
   } outcome_type;

   localparam logic [2:0] UNIT_NONE  = 3'd5;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_STORE = 2'd2;
   localparam logic [1:0] KIND_BAR   = 2'd3;

   localparam logic [2:0] CSR_ACTIVE = 3'd0;
   localparam logic [2:0] CSR_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_INT    = 3'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  warp_slot;
      logic [2:0]  exec_unit;
      logic [1:0]  inst_kind;
      logic        has_dest;
      logic [5:0]  dest_reg;
      logic [1:0]  src_count;
      logic [5:0]  src_a;
      logic [5:0]  src_b;
      logic [5:0]  src_c;
      logic [9:0]  latency;
   } item_type;

   // Stored instruction: 3+2+1+6+2+18+10 = 42 bits
   typedef struct packed {
      logic [2:0]  unit;
      logic [1:0]  kind;
      logic        has_dest;
      logic [5:0]  dest;
      logic [1:0]  nsrc;
      logic [5:0]  src_a;
      logic [5:0]  src_b;
      logic [5:0]  src_c;
      logic [9:0]  lat;
   } inst_type;

   typedef struct packed {
      logic [2:0]  warp_id;
      logic [2:0]  outcome;
      logic [31:0] cycle_now;
      logic        all_done;
      logic        last;
   } rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

### sv/wis_ram.sv
module wis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/wis_front.sv
module wis_front import wis_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   output logic     q_valid,
   input  logic     q_pop,
   output item_type q_item
);

   // Two-entry queue between the request port and the engine
   item_type   buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = buf_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (q_pop && q_valid) begin
         rd_in = ~rd_ff;
      end
      case ({push, q_pop && q_valid})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= req_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (rd_ff == wr_ff))
      else $error("empty queue pointers differ");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (rd_ff == wr_ff))
      else $error("full queue pointers differ");

endmodule

### sv/wis_engine.sv
module wis_engine import wis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_pop,
   input  item_type    q_item,
   input  logic [3:0]  cfg_active,
   input  logic [3:0]  cfg_width,
   input  logic [3:0]  cfg_cap [5],
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCLR, ST_DECIDE, ST_FIND, ST_IREAD, ST_SREAD,
      ST_EVAL, ST_EMIT, ST_DONE, ST_OUT
   } st_type;

   st_type state_ff, state_in;

   logic [PC_W-1:0]   plen_ff [NUM_WARPS];
   logic [PC_W-1:0]   pc_ff   [NUM_WARPS];
   logic [31:0]       bar_ff  [NUM_WARPS];
   logic [31:0]       memc_ff [NUM_WARPS];
   logic [31:0]       ldb_ff  [NUM_WARPS];
   logic [WARP_W-1:0] rr_ff;
   logic [31:0]       cyc_ff;
   // Scoreboard clear pointer: sweeps every entry after reset, restart and clear
   logic [SADDR_W:0]  sclr_ff;

   logic [3:0]        wt_ff;     // warps in walk
   logic [3:0]        off_ff;
   logic [WARP_W-1:0] w_ff;
   logic [3:0]        issued_ff;
   logic [3:0]        used_ff [5];
   logic [1:0]        sidx_ff;
   logic              raw_ff;
   logic [2:0]        oc_ff;
   logic              stop_ff;
   rsp_type           out_ff;
   logic              out_v_ff, out_v_in;

   // Walk results, {warp, outcome}, held until the walk ends
   logic [5:0]        res_ff [NUM_WARPS];
   logic [3:0]        rcnt_ff;
   logic [3:0]        ridx_ff;
   logic [31:0]       tcyc_ff;

   // Instruction store
   logic               istore_we;
   logic [IADDR_W-1:0] istore_wa, istore_ra;
   logic [INST_W-1:0]  istore_rd;
   inst_type           inst;
   inst_type           new_inst;

   // Scoreboard
   logic               sb_we;
   logic [SADDR_W-1:0] sb_wa, sb_ra;
   logic [31:0]        sb_wd, sb_rd;

   assign inst = inst_type'(istore_rd);

   wis_ram #(.WIDTH(INST_W), .DEPTH(NUM_WARPS * PROG_DEPTH)) u_istore (
      .clock(clock), .wr_en(istore_we), .wr_addr(istore_wa),
      .wr_data(INST_W'(new_inst)), .rd_addr(istore_ra), .rd_data(istore_rd));

   wis_ram #(.WIDTH(32), .DEPTH(NUM_WARPS * NUM_REGS)) u_sboard (
      .clock(clock), .wr_en(sb_we), .wr_addr(sb_wa),
      .wr_data(sb_wd), .rd_addr(sb_ra), .rd_data(sb_rd));

   // Walk length and completion
   logic [3:0] wtotal;
   logic       every_done;
   assign wtotal = (cfg_active > 4'(NUM_WARPS)) ? 4'(NUM_WARPS) : cfg_active;

   always_comb begin
      every_done = 1'b1;
      for (int i = 0; i < NUM_WARPS; i++) begin
         if ((4'(i) < wtotal) && (pc_ff[i] < plen_ff[i])) begin
            every_done = 1'b0;
         end
      end
   end

   // Tick with nothing to run, and a start warp left beyond a shrunk walk
   logic idle_tick, rr_over;
   assign idle_tick = (wtotal == 4'd0) || every_done;
   assign rr_over   = ({1'b0, rr_ff} >= wtotal);

   // Current warp index: (rr + off) mod W, both below W
   logic [4:0]        wsum;
   logic [WARP_W-1:0] wcur;
   assign wsum = 5'(rr_ff) + 5'(off_ff);
   assign wcur = (wsum >= 5'(wt_ff)) ? WARP_W'(wsum - 5'(wt_ff)) : WARP_W'(wsum);

   logic unfinished;
   assign unfinished = pc_ff[wcur] < plen_ff[wcur];

   // Address the source one step ahead while evaluating, the read is registered
   logic [1:0] sidx_rd;
   assign sidx_rd = (state_ff == ST_EVAL) ? sidx_ff + 2'd1 : sidx_ff;

   logic [5:0] src_sel;
   always_comb begin
      case (sidx_rd)
         2'd0:    src_sel = inst.src_a;
         2'd1:    src_sel = inst.src_b;
         default: src_sel = inst.src_c;
      endcase
   end

   logic [1:0] nsrc;
   assign nsrc = (inst.nsrc > 2'(NSRC)) ? 2'(NSRC) : inst.nsrc;

   logic [31:0] done_t;
   assign done_t = sat_add(cyc_ff, {22'd0, inst.lat});

   logic busy;
   assign busy = out_v_ff && rsp_stall;

   logic [2:0] load_unit;
   assign load_unit = (q_item.exec_unit > UNIT_NONE) ? UNIT_NONE : q_item.exec_unit;
   assign new_inst = '{unit: load_unit, kind: q_item.inst_kind, has_dest: q_item.has_dest,
                       dest: q_item.dest_reg, nsrc: q_item.src_count,
                       src_a: q_item.src_a, src_b: q_item.src_b, src_c: q_item.src_c,
                       lat: q_item.latency};

   logic load_ok;
   assign load_ok = ({1'b0, q_item.warp_slot} < 4'(NUM_WARPS))
                 && (plen_ff[q_item.warp_slot] < PC_W'(PROG_DEPTH));

   // A load into an active warp leaves that warp unfinished
   logic load_done;
   assign load_done = every_done && !(load_ok && ({1'b0, q_item.warp_slot} < wtotal));

   logic struct_stall;
   assign struct_stall = (issued_ff >= cfg_width) ||
                         ((inst.unit < UNIT_NONE) && (used_ff[inst.unit] >= cfg_cap[inst.unit]));

   logic [5:0] res_cur;
   logic       last_res;
   assign res_cur  = res_ff[ridx_ff[WARP_W-1:0]];
   assign last_res = (ridx_ff + 4'd1 == rcnt_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !busy) begin
               unique case (mode_type'(q_item.mode))
                  MODE_LOAD:                state_in = ST_IDLE;
                  MODE_RESTART, MODE_CLEAR: state_in = ST_SCLR;
                  default:                  state_in = ST_DECIDE;
               endcase
            end
         end
         ST_SCLR:   if (sclr_ff[SADDR_W]) state_in = ST_IDLE;
         ST_DECIDE: begin
            if (idle_tick)    state_in = ST_OUT;
            else if (!rr_over) state_in = ST_FIND;
         end
         ST_FIND: begin
            if (off_ff == wt_ff || stop_ff) state_in = ST_DONE;
            else if (unfinished)            state_in = ST_IREAD;
         end
         ST_IREAD:  state_in = ST_SREAD;
         ST_SREAD:  state_in = ST_EVAL;
         ST_EVAL:   if (sidx_ff >= nsrc) state_in = ST_EMIT;
         ST_EMIT:   state_in = ST_FIND;
         ST_DONE:   state_in = ST_OUT;
         ST_OUT:    if (!busy && last_res) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop     = 1'b0;
      istore_we = 1'b0;
      istore_wa = {q_item.warp_slot, plen_ff[q_item.warp_slot][PADDR_W-1:0]};
      istore_ra = {wcur, pc_ff[wcur][PADDR_W-1:0]};
      sb_we     = 1'b0;
      sb_wa     = {w_ff, inst.dest[REG_W-1:0]};
      sb_wd     = done_t;
      sb_ra     = {w_ff, src_sel[REG_W-1:0]};
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !busy) begin
               q_pop = 1'b1;
               istore_we = (mode_type'(q_item.mode) == MODE_LOAD) && load_ok;
            end
         end
         ST_SCLR: begin
            sb_we = !sclr_ff[SADDR_W];
            sb_wa = sclr_ff[SADDR_W-1:0];
            sb_wd = '0;
         end
         ST_EMIT: begin
            sb_we = (oc_ff == OC_ISSUED) && inst.has_dest;
         end
         default: ;
      endcase
   end

   // Result valid: hold while stalled, raise on a new transfer
   always_comb begin
      out_v_in = out_v_ff && rsp_stall;
      if (!busy) begin
         if (state_ff == ST_OUT) out_v_in = 1'b1;
         if (state_ff == ST_IDLE && q_valid && mode_type'(q_item.mode) == MODE_LOAD)
            out_v_in = 1'b1;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCLR;
         sclr_ff  <= '0;
         out_v_ff <= 1'b0;
         rr_ff    <= '0;
         cyc_ff   <= '0;
         for (int i = 0; i < NUM_WARPS; i++) begin
            plen_ff[i] <= '0;
            pc_ff[i]   <= '0;
            bar_ff[i]  <= '0;
            memc_ff[i] <= '0;
            ldb_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid && !busy) begin
                  if (mode_type'(q_item.mode) == MODE_LOAD) begin
                     if (load_ok) plen_ff[q_item.warp_slot] <= plen_ff[q_item.warp_slot] + 1'b1;
                     out_ff <= '{warp_id: q_item.warp_slot,
                                 outcome: load_ok ? OC_LOADED : OC_FULL,
                                 cycle_now: cyc_ff, all_done: load_done, last: 1'b1};
                  end else if (mode_type'(q_item.mode) != MODE_TICK) begin
                     if (mode_type'(q_item.mode) == MODE_CLEAR)
                        for (int i = 0; i < NUM_WARPS; i++) plen_ff[i] <= '0;
                     for (int i = 0; i < NUM_WARPS; i++) begin
                        pc_ff[i]   <= '0;
                        bar_ff[i]  <= '0;
                        memc_ff[i] <= '0;
                        ldb_ff[i]  <= '0;
                     end
                     rr_ff   <= '0;
                     cyc_ff  <= '0;
                     sclr_ff <= '0;
                  end
               end
            end
            ST_SCLR: if (!sclr_ff[SADDR_W]) sclr_ff <= sclr_ff + 1'b1;
            ST_DECIDE: begin
               wt_ff      <= wtotal;
               off_ff     <= '0;
               issued_ff  <= '0;
               stop_ff    <= 1'b0;
               tcyc_ff    <= cyc_ff;
               ridx_ff    <= '0;
               res_ff[0]  <= {3'd0, OC_IDLE};
               rcnt_ff    <= idle_tick ? 4'd1 : 4'd0;
               for (int u = 0; u < 5; u++) used_ff[u] <= '0;
               // Fold the start warp back below the walk length
               if (!idle_tick && rr_over) rr_ff <= rr_ff - wtotal[WARP_W-1:0];
            end
            ST_FIND: begin
               if (!(off_ff == wt_ff || stop_ff) && !unfinished) off_ff <= off_ff + 1'b1;
               w_ff <= wcur;
            end
            ST_IREAD: sidx_ff <= '0;
            ST_SREAD: raw_ff <= 1'b0;
            ST_EVAL: begin
               // One source per step, read address runs one source ahead
               if (sidx_ff < nsrc) begin
                  if (sb_rd > cyc_ff) raw_ff <= 1'b1;
                  sidx_ff <= sidx_ff + 1'b1;
               end else begin
                  if (bar_ff[w_ff] > cyc_ff)
                     oc_ff <= OC_BARRIER;
                  else if ((inst.kind == KIND_STORE && memc_ff[w_ff] > cyc_ff) ||
                           (inst.kind == KIND_LOAD && ldb_ff[w_ff] > cyc_ff))
                     oc_ff <= OC_MEMORY;
                  else if (raw_ff)       oc_ff <= OC_RAW;
                  else if (struct_stall) oc_ff <= OC_STRUCT;
                  else                   oc_ff <= OC_ISSUED;
               end
            end
            ST_EMIT: begin
               // Record the outcome; transfers wait for the end of the walk
               res_ff[rcnt_ff[WARP_W-1:0]] <= {w_ff, oc_ff};
               rcnt_ff <= rcnt_ff + 1'b1;
               off_ff  <= off_ff + 1'b1;
               if (oc_ff == OC_ISSUED) begin
                  issued_ff <= issued_ff + 1'b1;
                  if (inst.unit < UNIT_NONE) used_ff[inst.unit] <= used_ff[inst.unit] + 1'b1;
                  if (issued_ff + 1'b1 >= cfg_width) stop_ff <= 1'b1;
                  if (inst.kind == KIND_LOAD || inst.kind == KIND_STORE)
                     if (done_t > memc_ff[w_ff]) memc_ff[w_ff] <= done_t;
                  if (inst.kind == KIND_STORE && done_t > ldb_ff[w_ff])
                     ldb_ff[w_ff] <= done_t;
                  if (inst.kind == KIND_BAR) bar_ff[w_ff] <= done_t;
                  pc_ff[w_ff] <= pc_ff[w_ff] + 1'b1;
               end
            end
            ST_DONE: begin
               rr_ff  <= (5'(rr_ff) + 5'd1 >= 5'(wt_ff)) ? '0 : rr_ff + 1'b1;
               cyc_ff <= sat_add(cyc_ff, 32'd1);
            end
            ST_OUT: begin
               if (!busy) begin
                  out_ff <= '{warp_id: res_cur[5:3], outcome: res_cur[2:0],
                              cycle_now: tcyc_ff, all_done: every_done, last: last_res};
                  ridx_ff <= ridx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_stall) |=> ($stable(out_ff) && out_v_ff))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (issued_ff <= cfg_width))
      else $error("issue count beyond width");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("pop outside idle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCLR) |-> !q_pop)
      else $error("item taken during scoreboard clear");

endmodule

### sv/warp_issue_scheduler_core.sv
// Warp issue scheduler. Items are queued two deep in front of a sequencer that
// handles one item at a time. A load is handled straight from the idle state,
// and its result transfer is offered on the next cycle. A tick walks the active
// warps round-robin from the rotating start. Each finished warp is skipped in
// the find step. Each unfinished warp passes through find, instruction store
// read, first scoreboard read, one evaluate step per source plus the decision,
// and record. The scoreboard RAM has a single read port, so sources are read
// one per cycle. The results of a tick are held until the walk ends, because
// all_done depends on every issue in the tick. They then leave one per cycle
// while rsp_stall is low. When active_warps has shrunk below the start warp,
// the start is first folded back into range. After reset, and after each
// restart or clear, the 512-entry scoreboard is cleared one entry per cycle,
// and no item is taken from the queue during the clear. Configuration writes
// are always accepted and belong between runs, with nothing in flight.
module warp_issue_scheduler_core import wis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_warp_slot,
   input  logic [2:0]  req_exec_unit,
   input  logic [1:0]  req_inst_kind,
   input  logic        req_has_dest,
   input  logic [5:0]  req_dest_reg,
   input  logic [1:0]  req_src_count,
   input  logic [5:0]  req_src_a,
   input  logic [5:0]  req_src_b,
   input  logic [5:0]  req_src_c,
   input  logic [9:0]  req_latency,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_warp_id,
   output logic [2:0]  rsp_outcome,
   output logic [31:0] rsp_cycle_now,
   output logic        rsp_all_done,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_data
);

   logic [3:0] active_ff, width_ff;
   logic [3:0] cap_ff [5];

   assign csr_ready = 1'b1;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 4'd8;
         width_ff  <= 4'd1;
         for (int u = 0; u < 5; u++) cap_ff[u] <= 4'd1;
      end else if (csr_valid) begin
         if (csr_index == CSR_ACTIVE) active_ff <= csr_data;
         else if (csr_index == CSR_WIDTH) width_ff <= csr_data;
         else if (csr_index < 3'd7) cap_ff[csr_index - CSR_INT] <= csr_data;
      end
   end

   item_type req_item, q_item;
   logic     q_valid, q_pop;
   rsp_type  rsp_data;

   assign req_item = '{mode: req_mode, warp_slot: req_warp_slot, exec_unit: req_exec_unit,
                       inst_kind: req_inst_kind, has_dest: req_has_dest,
                       dest_reg: req_dest_reg, src_count: req_src_count,
                       src_a: req_src_a, src_b: req_src_b, src_c: req_src_c,
                       latency: req_latency};

   wis_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_item(req_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

   wis_engine u_engine (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .cfg_active(active_ff), .cfg_width(width_ff), .cfg_cap(cap_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

   assign rsp_warp_id   = rsp_data.warp_id;
   assign rsp_outcome   = rsp_data.outcome;
   assign rsp_cycle_now = rsp_data.cycle_now;
   assign rsp_all_done  = rsp_data.all_done;
   assign rsp_last      = rsp_data.last;

endmodule

### bench/warp_issue_scheduler_core_chk.sv
module warp_issue_scheduler_core_chk import wis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_warp_slot,
   input  logic [2:0]  req_exec_unit,
   input  logic [1:0]  req_inst_kind,
   input  logic        req_has_dest,
   input  logic [5:0]  req_dest_reg,
   input  logic [1:0]  req_src_count,
   input  logic [5:0]  req_src_a,
   input  logic [5:0]  req_src_b,
   input  logic [5:0]  req_src_c,
   input  logic [9:0]  req_latency,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_warp_id,
   input  logic [2:0]  rsp_outcome,
   input  logic [31:0] rsp_cycle_now,
   input  logic        rsp_all_done,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_data,
   output int          pending,
   output int          errors
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the scheduler state
   inst_type    prog_mem [NUM_WARPS*PROG_DEPTH];
   int unsigned prog_len [NUM_WARPS];
   int unsigned warp_pc [NUM_WARPS];
   logic [31:0] reg_ready [NUM_WARPS*NUM_REGS];
   logic [31:0] bar_until [NUM_WARPS];
   logic [31:0] mem_done [NUM_WARPS];
   logic [31:0] ld_block [NUM_WARPS];
   int unsigned rr_next;
   logic [31:0] cyc;
   logic [3:0]  regs [7];
   rsp_type     outcome_q [$];

   task automatic report(input string msg);
      $display("%0t: MISMATCH %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic int unsigned warps_in_run();
      return (regs[CSR_ACTIVE] > NUM_WARPS) ? NUM_WARPS : regs[CSR_ACTIVE];
   endfunction

   function automatic bit run_finished();
      for (int i = 0; i < warps_in_run(); i++)
         if (warp_pc[i] < prog_len[i]) return 0;
      return 1;
   endfunction

   function automatic void restart_run();
      for (int i = 0; i < NUM_WARPS; i++) begin
         warp_pc[i] = 0;
         bar_until[i] = 0;
         mem_done[i] = 0;
         ld_block[i] = 0;
      end
      for (int i = 0; i < NUM_WARPS*NUM_REGS; i++) reg_ready[i] = 0;
      rr_next = 0;
      cyc = 0;
   endfunction

   // Work out the outcomes of one accepted item and queue them
   task automatic schedule_item(input item_type it);
      rsp_type     outs [$];
      rsp_type     r;
      inst_type    s;
      int unsigned nw, w, used [6], issued, ns;
      logic [5:0]  srcs [3];
      logic [31:0] now, done;
      logic [2:0]  oc;
      logic [2:0]  u;
      if (it.mode == MODE_RESTART || it.mode == MODE_CLEAR) begin
         if (it.mode == MODE_CLEAR)
            for (int i = 0; i < NUM_WARPS; i++) prog_len[i] = 0;
         restart_run();
         return;
      end
      r = '0;
      r.cycle_now = cyc;
      if (it.mode == MODE_LOAD) begin
         w = it.warp_slot;
         r.warp_id = it.warp_slot;
         if (w < NUM_WARPS && prog_len[w] < PROG_DEPTH) begin
            u = (it.exec_unit > UNIT_NONE) ? UNIT_NONE : it.exec_unit;
            prog_mem[w*PROG_DEPTH + prog_len[w]] = '{u, it.inst_kind, it.has_dest,
               it.dest_reg, it.src_count, it.src_a, it.src_b, it.src_c, it.latency};
            prog_len[w]++;
            r.outcome = OC_LOADED;
         end else
            r.outcome = OC_FULL;
         outs = {outs, r};
      end else begin
         nw = warps_in_run();
         if (nw == 0 || run_finished()) begin
            r.outcome = OC_IDLE;
            outs = {outs, r};
         end else begin
            foreach (used[i]) used[i] = 0;
            issued = 0;
            now = cyc;
            for (int off = 0; off < nw; off++) begin
               w = (rr_next + off) % nw;
               if (warp_pc[w] >= prog_len[w]) continue;
               s = prog_mem[w*PROG_DEPTH + warp_pc[w]];
               ns = (s.nsrc > NSRC) ? NSRC : s.nsrc;
               srcs[0] = s.src_a;
               srcs[1] = s.src_b;
               srcs[2] = s.src_c;
               oc = OC_ISSUED;
               // Stall priority: barrier, memory order, RAW, structural
               if (bar_until[w] > now) oc = OC_BARRIER;
               else if ((s.kind == KIND_STORE && mem_done[w] > now) ||
                        (s.kind == KIND_LOAD && ld_block[w] > now)) oc = OC_MEMORY;
               else begin
                  for (int j = 0; j < ns; j++)
                     if (reg_ready[w*NUM_REGS + srcs[j]] > now) oc = OC_RAW;
                  if (oc == OC_ISSUED && (issued >= regs[CSR_WIDTH] ||
                      (s.unit < UNIT_NONE && used[s.unit] >= regs[CSR_INT + s.unit])))
                     oc = OC_STRUCT;
               end
               if (oc == OC_ISSUED) begin
                  done = add_sat(now, 32'(s.lat));
                  used[s.unit]++;
                  issued++;
                  if (s.has_dest) reg_ready[w*NUM_REGS + s.dest] = done;
                  if (s.kind == KIND_LOAD || s.kind == KIND_STORE) begin
                     if (done > mem_done[w]) mem_done[w] = done;
                     if (s.kind == KIND_STORE && done > ld_block[w]) ld_block[w] = done;
                  end
                  if (s.kind == KIND_BAR) bar_until[w] = done;
                  warp_pc[w]++;
               end
               r.warp_id = w[2:0];
               r.outcome = oc;
               outs = {outs, r};
               if (oc == OC_ISSUED && issued >= regs[CSR_WIDTH]) break;
            end
            rr_next = (rr_next + 1) % nw;
            cyc = add_sat(cyc, 1);
         end
      end
      // Mark completion state after the update, flag the final transfer
      foreach (outs[k]) begin
         outs[k].all_done = run_finished();
         outs[k].last = (k == outs.size() - 1);
         outcome_q = {outcome_q, outs[k]};
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_WARPS; i++) prog_len[i] = 0;
      restart_run();
      regs[0] = 8;
      for (int i = 1; i < 7; i++) regs[i] = 1;
   end

   always @(posedge clock) begin
      rsp_type  want;
      item_type it;
      if (!reset) begin
         if (csr_valid && csr_ready && csr_index < 7) regs[csr_index] = csr_data;
         // Compare each result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0)
               report($sformatf("unexpected result warp %0d outcome %0d",
                  rsp_warp_id, rsp_outcome));
            else begin
               want = outcome_q.pop_front();
               if (rsp_warp_id !== want.warp_id)
                  report($sformatf("warp_id %0d, want %0d", rsp_warp_id, want.warp_id));
               if (rsp_outcome !== want.outcome)
                  report($sformatf("outcome %0d, want %0d (warp %0d)",
                     rsp_outcome, want.outcome, want.warp_id));
               if (rsp_cycle_now !== want.cycle_now)
                  report($sformatf("cycle_now %0d, want %0d", rsp_cycle_now, want.cycle_now));
               if (rsp_all_done !== want.all_done)
                  report($sformatf("all_done %b, want %b", rsp_all_done, want.all_done));
               if (rsp_last !== want.last)
                  report($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            it = '{req_mode, req_warp_slot, req_exec_unit, req_inst_kind, req_has_dest,
               req_dest_reg, req_src_count, req_src_a, req_src_b, req_src_c, req_latency};
            schedule_item(it);
         end
         pending <= outcome_q.size();
      end
   end

endmodule

### bench/warp_issue_scheduler_core_tb.sv
module warp_issue_scheduler_core_tb;
   import wis_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_mode = 0;
   logic [2:0]  req_warp_slot = 0;
   logic [2:0]  req_exec_unit = 0;
   logic [1:0]  req_inst_kind = 0;
   logic        req_has_dest = 0;
   logic [5:0]  req_dest_reg = 0;
   logic [1:0]  req_src_count = 0;
   logic [5:0]  req_src_a = 0;
   logic [5:0]  req_src_b = 0;
   logic [5:0]  req_src_c = 0;
   logic [9:0]  req_latency = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_warp_id;
   logic [2:0]  rsp_outcome;
   logic [31:0] rsp_cycle_now;
   logic        rsp_all_done;
   logic        rsp_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [3:0]  csr_data = 0;
   int          pending;
   int          errors;
   bit          no_gaps = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   warp_issue_scheduler_core dut (.*);
   warp_issue_scheduler_core_chk chk (.*);

   // Random receiver stall, drawn once per result transfer
   always @(posedge clock) begin
      static int hold = 0;
      if (hold > 0) begin
         hold--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
         if (rsp_valid) hold = no_gaps ? 0 : $urandom_range(0, 4);
      end
   end

   task automatic send(input item_type it);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= it.mode;
      req_warp_slot <= it.warp_slot;
      req_exec_unit <= it.exec_unit;
      req_inst_kind <= it.inst_kind;
      req_has_dest <= it.has_dest;
      req_dest_reg <= it.dest_reg;
      req_src_count <= it.src_count;
      req_src_a <= it.src_a;
      req_src_b <= it.src_b;
      req_src_c <= it.src_c;
      req_latency <= it.latency;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_op(input mode_type m);
      item_type it;
      it = '0;
      it.mode = m;
      it.latency = 10'($urandom);
      it.dest_reg = 6'($urandom);
      send(it);
   endtask

   task automatic load_inst(input logic [2:0] w, input logic [2:0] u, input logic [1:0] k,
                            input logic hd, input logic [5:0] d, input logic [1:0] n,
                            input logic [5:0] a, input logic [5:0] b, input logic [5:0] c,
                            input logic [9:0] lat);
      send('{MODE_LOAD, w, u, k, hd, d, n, a, b, c, lat});
   endtask

   // Random instruction; narrow register range makes dependencies common
   task automatic load_random(input logic [2:0] w);
      logic [5:0] rmask;
      logic [9:0] lat;
      rmask = ($urandom_range(0, 3) == 0) ? 6'h3f : 6'h07;
      lat = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
      load_inst(w, 3'($urandom_range(0, 7)), 2'($urandom), 1'($urandom),
         6'($urandom) & rmask, 2'($urandom), 6'($urandom) & rmask,
         6'($urandom) & rmask, 6'($urandom) & rmask, lat);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Idle the block fully, covering a scoreboard clear pass
   task automatic write_regs(input logic [3:0] v [7]);
      drain();
      repeat (700) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1;
         csr_index <= i[2:0];
         csr_data <= v[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 0;
   endtask

   initial begin
      logic [3:0] v [7];
      int nload, nticks;
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed: units, kinds, dependencies and latency extremes
      load_inst(0, 0, 0, 1, 1, 0, 0, 0, 0, 3);
      load_inst(0, 1, 0, 1, 2, 1, 1, 0, 0, 0);
      load_inst(1, 2, KIND_LOAD, 1, 63, 0, 0, 0, 0, 1023);
      load_inst(1, 2, KIND_STORE, 0, 0, 2, 63, 63, 0, 5);
      load_inst(1, 2, KIND_LOAD, 0, 0, 0, 0, 0, 0, 0);
      load_inst(2, UNIT_NONE, KIND_BAR, 0, 0, 0, 0, 0, 0, 4);
      load_inst(2, 3, 0, 1, 61, 3, 63, 62, 61, 0);
      load_inst(3, 4, 0, 0, 0, 0, 0, 0, 0, 1);
      load_inst(3, 7, KIND_STORE, 1, 5, 3, 5, 5, 5, 1023);
      load_inst(4, 6, 0, 1, 0, 1, 0, 0, 0, 2);
      repeat (8) send_op(MODE_TICK);
      send_op(MODE_RESTART);
      repeat (3) send_op(MODE_TICK);
      send_op(MODE_CLEAR);
      send_op(MODE_TICK);

      // Random phases with varying register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: v = '{8, 8, 8, 8, 8, 8, 8};
            1: v = '{1, 1, 0, 0, 0, 0, 0};
            2: v = '{15, 15, 15, 15, 15, 15, 15};
            3: v = '{0, 1, 1, 1, 1, 1, 1};
            default: begin
               v[0] = 4'($urandom_range(1, 8));
               v[1] = 4'($urandom_range(1, 8));
               for (int i = 2; i < 7; i++) v[i] = 4'($urandom_range(0, 8));
            end
         endcase
         write_regs(v);
         no_gaps = (ph % 3 == 2);
         send_op(MODE_CLEAR);
         if (ph == 5) begin
            // Fill one program store to overflow
            repeat (PROG_DEPTH + 2) load_random(6);
            send_op(MODE_RESTART);
         end
         nload = $urandom_range(3, 8);
         for (int i = 0; i < nload; i++) load_random(3'($urandom_range(0, 7)));
         nticks = $urandom_range(5, 10);
         for (int i = 0; i < nticks; i++) begin
            if (i == nticks / 2) drain();
            case ($urandom_range(0, 19))
               0: send_op(MODE_RESTART);
               1: load_random(3'($urandom));
               2: send_op(mode_type'($urandom_range(0, 3)));
               default: send_op(MODE_TICK);
            endcase
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("warp_issue_scheduler_core test passed");
      else
         $display("warp_issue_scheduler_core test failed");
      $finish;
   end

   initial begin
      #10ms;
      $display("warp_issue_scheduler_core test failed");
      $finish;
   end

endmodule
